// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the 2x2 mip downsampler RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKRST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

// ----- rtl/mbd_pkg.sv -----
// Shared types, constants and helpers of the 2x2 mip downsampler.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mbd_pkg;

   // Configuration port.
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = CSR_INDEX_W'(1);

   // Default image limits.
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Channel widths: an 8-bit sample, a 9-bit pair sum, a 10-bit square sum.
   localparam int CHAN_W = 8;
   localparam int PAIR_W = CHAN_W + 1;
   localparam int QUAD_W = CHAN_W + 2;

   // One pixel, red in the lowest bits.
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgba_type;

   // Horizontal pair sums of one pixel pair, as kept in the line store.
   typedef struct packed {
      logic [PAIR_W-1:0] alpha;
      logic [PAIR_W-1:0] blue;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] red;
   } pair_type;

   // What the front end hands to the summing stage for one target pixel.
   typedef struct packed {
      pair_type pair;
      logic     double_pair;
      logic     row_end;
      logic     image_end;
   } stage_type;

   // Line store access strobes.
   typedef struct packed {
      logic write_en;
      logic read_en;
   } line_ctl_type;

   // Size register value forced into 1..maxv.
   function automatic logic [31:0] clamp_size(logic [CSR_DATA_W-1:0] v, logic [31:0] maxv);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide == 32'd0) begin
         return 32'd1;
      end else if (wide > maxv) begin
         return maxv;
      end
      return wide;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mbd_line_ram.sv -----
// Line store of horizontal pair sums for one even source row.
// Single address, one write or one registered read per cycle; uses mbd_pkg.
`default_nettype none

module mbd_line_ram
   import mbd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH / 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire line_ctl_type  ctl,
   input  wire logic [AW-1:0] addr,
   input  wire pair_type      wr_data,
   output      pair_type      rd_data
);

   pair_type mem_ff [DEPTH];
   pair_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         mem_ff[addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.read_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/mbd_front.sv -----
// Front end: size registers, raster counters, horizontal pairing and line store control.
// Uses mbd_pkg; drives mbd_line_ram and feeds mbd_back.
`default_nettype none
`include "assert_macros.svh"

module mbd_front
   import mbd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int DEPTH     = MAX_WIDTH / 2,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW        = $clog2(MAX_WIDTH),
   localparam int RW        = $clog2(MAX_HEIGHT)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   accept,
   input  wire rgba_type               pixel,
   output      logic                   emit,
   output      stage_type              stage,
   output      line_ctl_type           line_ctl,
   output      logic [AW-1:0]          line_addr,
   output      pair_type               line_wdata
);

   // Geometry derived from the size registers.
   logic [CW-1:0] w_last_ff, w_last_in;
   logic [CW-1:0] x_last_ff, x_last_in;
   logic          w_one_ff, w_one_in;
   logic          w_drop_ff, w_drop_in;
   logic [RW-1:0] h_last_ff, h_last_in;
   logic [RW-1:0] y_last_ff, y_last_in;
   logic          h_one_ff, h_one_in;
   logic          h_drop_ff, h_drop_in;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   rgba_type      held_ff, held_in;

   logic [31:0]   w_size, w_half, h_size, h_half;
   logic          col_last, row_last, col_keep, row_keep;
   logic          have_pair, hold_load;
   logic [CW-1:0] x_pos;
   logic [RW-1:0] y_pos;
   pair_type      pair;

   // Clamp the written size and work out the last positions and the odd-size drop.
   always_comb begin
      w_size    = clamp_size(csr_wdata, 32'(MAX_WIDTH));
      w_half    = w_size >> 1;
      w_last_in = CW'(w_size - 32'd1);
      x_last_in = (w_half == 32'd0) ? '0 : CW'(w_half - 32'd1);
      w_one_in  = (w_size == 32'd1);
      w_drop_in = w_size[0] && !w_one_in;
      h_size    = clamp_size(csr_wdata, 32'(MAX_HEIGHT));
      h_half    = h_size >> 1;
      h_last_in = RW'(h_size - 32'd1);
      y_last_in = (h_half == 32'd0) ? '0 : RW'(h_half - 32'd1);
      h_one_in  = (h_size == 32'd1);
      h_drop_in = h_size[0] && !h_one_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= '0;
         x_last_ff <= '0;
         w_one_ff  <= 1'b1;
         w_drop_ff <= 1'b0;
         h_last_ff <= '0;
         y_last_ff <= '0;
         h_one_ff  <= 1'b1;
         h_drop_ff <= 1'b0;
      end else if (csr_wen) begin
         if (csr_index == CSR_SOURCE_WIDTH) begin
            w_last_ff <= w_last_in;
            x_last_ff <= x_last_in;
            w_one_ff  <= w_one_in;
            w_drop_ff <= w_drop_in;
         end
         if (csr_index == CSR_SOURCE_HEIGHT) begin
            h_last_ff <= h_last_in;
            y_last_ff <= y_last_in;
            h_one_ff  <= h_one_in;
            h_drop_ff <= h_drop_in;
         end
      end
   end

   // Horizontal pairing: an even column is held, the odd column completes the pair.
   always_comb begin
      col_last  = (col_ff == w_last_ff);
      row_last  = (row_ff == h_last_ff);
      col_keep  = !(w_drop_ff && col_last);
      row_keep  = !(h_drop_ff && row_last);
      have_pair = 1'b0;
      hold_load = 1'b0;
      x_pos     = '0;
      pair.red   = {pixel.red, 1'b0};
      pair.green = {pixel.green, 1'b0};
      pair.blue  = {pixel.blue, 1'b0};
      pair.alpha = {pixel.alpha, 1'b0};
      if (w_one_ff) begin
         have_pair = 1'b1;
      end else if (col_keep) begin
         if (col_ff[0]) begin
            have_pair  = 1'b1;
            x_pos      = col_ff >> 1;
            pair.red   = PAIR_W'(held_ff.red) + PAIR_W'(pixel.red);
            pair.green = PAIR_W'(held_ff.green) + PAIR_W'(pixel.green);
            pair.blue  = PAIR_W'(held_ff.blue) + PAIR_W'(pixel.blue);
            pair.alpha = PAIR_W'(held_ff.alpha) + PAIR_W'(pixel.alpha);
         end else begin
            hold_load = 1'b1;
         end
      end
   end

   // Vertical pairing: even rows fill the line store, odd rows read it back.
   always_comb begin
      emit              = 1'b0;
      y_pos             = '0;
      line_ctl.write_en = 1'b0;
      line_ctl.read_en  = 1'b0;
      stage.double_pair = 1'b0;
      if (have_pair) begin
         if (h_one_ff) begin
            emit              = 1'b1;
            stage.double_pair = 1'b1;
         end else if (row_keep) begin
            if (row_ff[0]) begin
               emit             = 1'b1;
               y_pos            = row_ff >> 1;
               line_ctl.read_en = accept;
            end else begin
               line_ctl.write_en = accept;
            end
         end
      end
      stage.pair      = pair;
      stage.row_end   = (x_pos == x_last_ff);
      stage.image_end = (x_pos == x_last_ff) && (y_pos == y_last_ff);
      line_addr       = AW'(x_pos);
      line_wdata      = pair;
   end

   // Raster position and held pixel.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (accept) begin
         if (hold_load) begin
            held_in = pixel;
         end
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else if (csr_wen) begin
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
      end
   end

   `ASSERT_CLKRST(a_col_in_range, clock, reset, col_ff <= w_last_ff,
      "column counter passed the last source column")
   `ASSERT_CLKRST(a_row_in_range, clock, reset, row_ff <= h_last_ff,
      "row counter passed the last source row")
   `ASSERT_CLK(a_line_one_access, clock, !(line_ctl.write_en && line_ctl.read_en),
      "line store written and read in the same cycle")

endmodule

`default_nettype wire

// ----- rtl/mbd_back.sv -----
// Back end: vertical sum of the pair sums, truncating average and result register.
// Uses mbd_pkg; takes the front end's stage data and the line store read data.
`default_nettype none
`include "assert_macros.svh"

module mbd_back
   import mbd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire stage_type stage,
   input  wire pair_type  line_rdata,
   output      logic      stage_free,
   output      logic      rsp_tvalid,
   input  wire logic      rsp_tready,
   output      rgba_type  rsp_pixel,
   output      logic      rsp_row_end,
   output      logic      rsp_image_end
);

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff;
   logic      out_valid_ff, out_valid_in;
   rgba_type  out_pixel_ff, out_pixel_in;
   logic      out_row_end_ff, out_image_end_ff;
   logic      out_free;
   pair_type  upper;
   logic [QUAD_W-1:0] sum_r, sum_g, sum_b, sum_a;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign stage_free = !s1_valid_ff || out_free;

   // Add the stored upper pair, or count the only pair twice for a one-row image.
   always_comb begin
      upper = s1_ff.double_pair ? s1_ff.pair : line_rdata;
      sum_r = QUAD_W'(upper.red) + QUAD_W'(s1_ff.pair.red);
      sum_g = QUAD_W'(upper.green) + QUAD_W'(s1_ff.pair.green);
      sum_b = QUAD_W'(upper.blue) + QUAD_W'(s1_ff.pair.blue);
      sum_a = QUAD_W'(upper.alpha) + QUAD_W'(s1_ff.pair.alpha);
      out_pixel_in.red   = sum_r[QUAD_W-1:2];
      out_pixel_in.green = sum_g[QUAD_W-1:2];
      out_pixel_in.blue  = sum_b[QUAD_W-1:2];
      out_pixel_in.alpha = sum_a[QUAD_W-1:2];
   end

   // Stage and result valid flags.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (load) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= stage;
      end
      if (out_free) begin
         out_pixel_ff     <= out_pixel_in;
         out_row_end_ff   <= s1_ff.row_end;
         out_image_end_ff <= s1_ff.image_end;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_pixel     = out_pixel_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_image_end = out_image_end_ff;

   `ASSERT_CLKRST(a_stage_holds, clock, reset, (s1_valid_ff && !out_free) |=> s1_valid_ff,
      "stalled request left the summing stage")
   `ASSERT_CLKRST(a_stage_moves, clock, reset, (s1_valid_ff && out_free) |=> out_valid_ff,
      "request from the summing stage did not reach the result register")
   `ASSERT_CLKRST(a_image_end_row, clock, reset,
      (out_valid_ff && out_image_end_ff) |-> out_row_end_ff,
      "image end flagged on a pixel that does not end a row")

endmodule

`default_nettype wire

// ----- rtl/mip_box_downsample_2x2_unit.sv -----
// Top level of the 2x2 box filter mip downsampler.
// Uses mbd_pkg, mbd_front, mbd_line_ram and mbd_back.
//
// Source RGBA8 pixels enter in raster order at one pixel per clock unless the output
// stalls, and the next mip level leaves as truncated 2x2 averages, one registered
// result per completed square. In the single port line store (MAX_WIDTH/2 entries of
// four 9-bit pair sums) an even row writes one entry per pixel pair and an odd row
// reads it back, never both in a cycle. Odd sizes above one drop the last column or
// row, a size of one reuses the sample. Writing either size register restarts the
// frame; the user must write the registers only while no request is in flight, which
// the block does not enforce. No clearing pass is needed.
`default_nettype none

module mip_box_downsample_2x2_unit
   import mbd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration writes.
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   // Source pixels.
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [31:0]            req_tdata,  // red_in, green_in, blue_in, alpha_in
   // Target pixels.
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [31:0]            rsp_tdata,  // red_out, green_out, blue_out, alpha_out
   output      logic                   rsp_tlast,  // row_end
   output      logic [0:0]             rsp_tuser   // image_end
);

   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic         accept;
   logic         emit;
   logic         stage_free;
   stage_type    stage;
   line_ctl_type line_ctl;
   logic [AW-1:0] line_addr;
   pair_type     line_wdata, line_rdata;
   rgba_type     rsp_pixel;
   logic         rsp_row_end, rsp_image_end;

   assign req_tready = stage_free;
   assign accept     = req_tvalid && stage_free;

   mbd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .pixel      (rgba_type'(req_tdata)),
      .emit       (emit),
      .stage      (stage),
      .line_ctl   (line_ctl),
      .line_addr  (line_addr),
      .line_wdata (line_wdata)
   );

   mbd_line_ram #(
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .ctl     (line_ctl),
      .addr    (line_addr),
      .wr_data (line_wdata),
      .rd_data (line_rdata)
   );

   mbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .load          (accept && emit),
      .stage         (stage),
      .line_rdata    (line_rdata),
      .stage_free    (stage_free),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_pixel     (rsp_pixel),
      .rsp_row_end   (rsp_row_end),
      .rsp_image_end (rsp_image_end)
   );

   assign rsp_tdata    = rsp_pixel;
   assign rsp_tlast    = rsp_row_end;
   assign rsp_tuser[0] = rsp_image_end;

endmodule

`default_nettype wire
